/* rtl/lzss_window_decoder_unit_macros.svh */
// Assertion macros shared by the LZSS window decoder RTL.
`ifndef LZSS_WINDOW_DECODER_UNIT_MACROS_SVH
`define LZSS_WINDOW_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LZWD_CHECK(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LZWD_CHECK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/lzwd_pkg.sv */
// Types and constants shared by the LZSS window decoder modules.
`default_nettype none

package lzwd_pkg;

    localparam int WINDOW_DEPTH = 4096;
    localparam int WIN_AW       = 12;
    localparam int EXP_W        = 24;

    localparam logic [WIN_AW-1:0] WIN_START  = 12'hFEE;
    localparam logic [7:0]        BYTE_SPACE = 8'h20;
    localparam logic [4:0]        LEN_BIAS   = 5'd3;
    localparam logic [3:0]        FLAG_BITS  = 4'd8;

    typedef enum logic [1:0] {
        PH_FLAG  = 2'd0,
        PH_ITEM  = 2'd1,
        PH_PAIR2 = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE     = 2'd0,
        ST_DISPATCH = 2'd1,
        ST_COPY     = 2'd2,
        ST_STATUS   = 2'd3
    } ctrl_state_t;

    typedef struct packed {
        logic              push;
        logic [7:0]        push_data;
        logic [WIN_AW-1:0] rd_addr;
        logic              clear;
    } win_req_t;

endpackage

`default_nettype wire

/* rtl/lzwd_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module lzwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/lzwd_window.sv */
// History window: RAM, write pointer, fill tracking and write-to-read forwarding.
`default_nettype none

module lzwd_window
    import lzwd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire win_req_t req,
    output logic [7:0]    rd_data
);

    localparam logic [WIN_AW:0] FILL_FULL = (WIN_AW+1)'(WINDOW_DEPTH);

    logic [WIN_AW-1:0] wpos_reg, wpos_next;
    logic [WIN_AW:0]   fill_reg, fill_next;
    logic [WIN_AW-1:0] rel_addr;
    logic              rd_valid;
    logic              hit_reg, valid_reg;
    logic [7:0]        fwd_reg;
    logic [7:0]        ram_q;

    // Entries are written strictly in order from the start position, so an
    // entry holds data of the current frame only if it lies within the fill.
    always_comb begin
        wpos_next = wpos_reg;
        fill_next = fill_reg;
        if (req.clear) begin
            wpos_next = WIN_START;
            fill_next = '0;
        end else if (req.push) begin
            wpos_next = wpos_reg + 1'b1;
            if (fill_reg != FILL_FULL) begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    assign rel_addr = req.rd_addr - WIN_START;
    assign rd_valid = {1'b0, rel_addr} < fill_next;

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            wpos_reg <= WIN_START;
            fill_reg <= '0;
        end else begin
            wpos_reg <= wpos_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk) begin
        hit_reg   <= req.push && (req.rd_addr == wpos_reg);
        fwd_reg   <= req.push_data;
        valid_reg <= rd_valid;
    end

    lzwd_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (req.push),
        .waddr (wpos_reg),
        .wdata (req.push_data),
        .raddr (req.rd_addr),
        .rdata (ram_q)
    );

    assign rd_data = hit_reg ? fwd_reg : (valid_reg ? ram_q : BYTE_SPACE);

endmodule

`default_nettype wire

/* rtl/lzss_window_decoder_unit.sv */
// Top level of the LZSS decoder with a 4096-byte history window.
// The slave channel takes one compressed byte per item in s_tdata, with
// s_tlast marking the last compressed byte of a frame. The master channel
// returns decompressed bytes in m_tdata[7:0]; m_tuser marks the end-of-frame
// status item, whose m_tdata[8] tells whether exactly the expected number of
// bytes came out. m_tlast is set on the last item caused by an input item.
// The user writes the expected length through cfg_wr_en / cfg_wr_data only
// while idle; the block itself does not enforce this. One input item is
// handled at a time. A literal goes to the window and the output once the
// output slot is free; a match pair copies length + 3 bytes, at most 18,
// reading one byte and writing one byte per cycle while the slot is free,
// each read issued ahead. A frame end adds the status item. A literal's
// result passes the item register and the output register on its way to
// the master channel. Reset clears the parser, the counters and the window's
// fill tracking, so the whole window reads as spaces with no clearing pass;
// a frame end does the same. When the receiver stalls, the result waits in
// the output register and the copy loop holds its place until the slot frees.
`default_nettype none

`include "lzss_window_decoder_unit_macros.svh"

module lzss_window_decoder_unit
    import lzwd_pkg::*;
#(
    parameter int COUNT_BITS = 24
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Compressed input; s_tdata: in_byte [7:0]
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        s_tlast,
    // Decompressed output; m_tdata: out_byte [7:0], complete [8], zero [15:9]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,
    // m_tuser: is_status
    output logic             m_tuser,
    output logic             m_tlast,
    // Expected decompressed length of the frame
    input  wire logic        cfg_wr_en,
    input  wire logic [23:0] cfg_wr_data
);

    localparam int CMP_W = (COUNT_BITS > EXP_W) ? COUNT_BITS : EXP_W;

    ctrl_state_t           state_reg, state_next;
    phase_t                phase_reg, phase_next;
    logic [7:0]            byte_reg, byte_next;
    logic                  fend_reg, fend_next;
    logic [7:0]            flag_reg, flag_next;
    logic [3:0]            bits_reg, bits_next;
    logic [7:0]            offlo_reg, offlo_next;
    logic [WIN_AW-1:0]     off_reg, off_next;
    logic [4:0]            len_reg, len_next;
    logic [4:0]            cnt_reg, cnt_next;
    logic [COUNT_BITS-1:0] produced_reg, produced_next;
    logic                  limit_reg, limit_next;
    logic [EXP_W-1:0]      expected_reg;

    logic       m_valid_reg;
    logic [7:0] m_data_reg;
    logic       m_status_reg, m_last_reg, m_comp_reg;

    logic       load_out;
    logic [7:0] out_byte;
    logic       out_status, out_last, out_comp;
    logic       out_free;

    win_req_t              win_req;
    logic [7:0]            win_data;
    logic [COUNT_BITS-1:0] prod_inc;
    logic [CMP_W-1:0]      produced_ext, prod_inc_ext, expected_ext;
    logic                  at_limit, next_at_limit;
    logic [3:0]            bits_dec;
    phase_t                nb_phase;
    logic [4:0]            cnt_inc;
    ctrl_state_t           finish_state;

    // The output slot can take a new item when empty or being drained.
    assign out_free = !m_valid_reg || m_tready;

    // The produced count saturates at its all-ones value.
    assign prod_inc = (produced_reg == {COUNT_BITS{1'b1}}) ? produced_reg
                                                           : produced_reg + 1'b1;

    assign produced_ext  = CMP_W'(produced_reg);
    assign prod_inc_ext  = CMP_W'(prod_inc);
    assign expected_ext  = CMP_W'(expected_reg);
    assign at_limit      = produced_ext >= expected_ext;
    assign next_at_limit = prod_inc_ext >= expected_ext;

    // Moving on to the next flag bit.
    assign bits_dec = (bits_reg == 4'd0) ? 4'd0 : bits_reg - 1'b1;
    assign nb_phase = (bits_dec == 4'd0) ? PH_FLAG : PH_ITEM;

    assign cnt_inc      = cnt_reg + 1'b1;
    assign finish_state = fend_reg ? ST_STATUS : ST_IDLE;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        byte_next     = byte_reg;
        fend_next     = fend_reg;
        flag_next     = flag_reg;
        bits_next     = bits_reg;
        offlo_next    = offlo_reg;
        off_next      = off_reg;
        len_next      = len_reg;
        cnt_next      = cnt_reg;
        produced_next = produced_reg;
        limit_next    = limit_reg;

        load_out   = 1'b0;
        out_byte   = win_data;
        out_status = 1'b0;
        out_last   = 1'b0;
        out_comp   = 1'b0;

        win_req.push      = 1'b0;
        win_req.push_data = win_data;
        win_req.rd_addr   = off_reg + WIN_AW'(cnt_reg);
        win_req.clear     = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    byte_next  = s_tdata;
                    fend_next  = s_tlast;
                    state_next = ST_DISPATCH;
                end
            end

            ST_DISPATCH: begin
                if (limit_reg) begin
                    // Once the limit is hit, the rest of the frame is ignored.
                    state_next = finish_state;
                end else begin
                    case (phase_reg)
                        PH_ITEM: begin
                            if (flag_reg[0]) begin
                                if (at_limit) begin
                                    limit_next = 1'b1;
                                    state_next = finish_state;
                                end else if (out_free) begin
                                    load_out          = 1'b1;
                                    out_byte          = byte_reg;
                                    out_last          = !fend_reg;
                                    win_req.push      = 1'b1;
                                    win_req.push_data = byte_reg;
                                    produced_next     = prod_inc;
                                    flag_next         = {1'b0, flag_reg[7:1]};
                                    bits_next         = bits_dec;
                                    phase_next        = nb_phase;
                                    state_next        = finish_state;
                                end
                            end else begin
                                offlo_next = byte_reg;
                                phase_next = PH_PAIR2;
                                state_next = finish_state;
                            end
                        end
                        PH_PAIR2: begin
                            // Second pair byte: start the copy and fetch its
                            // first source byte.
                            off_next        = {byte_reg[7:4], offlo_reg};
                            len_next        = {1'b0, byte_reg[3:0]} + LEN_BIAS;
                            cnt_next        = 5'd0;
                            win_req.rd_addr = {byte_reg[7:4], offlo_reg};
                            state_next      = ST_COPY;
                        end
                        default: begin
                            flag_next  = byte_reg;
                            bits_next  = FLAG_BITS;
                            phase_next = PH_ITEM;
                            state_next = finish_state;
                        end
                    endcase
                end
            end

            ST_COPY: begin
                if (at_limit) begin
                    limit_next = 1'b1;
                    state_next = finish_state;
                end else if (out_free) begin
                    load_out          = 1'b1;
                    out_byte          = win_data;
                    out_last          = !fend_reg && ((cnt_inc == len_reg) || next_at_limit);
                    win_req.push      = 1'b1;
                    win_req.push_data = win_data;
                    win_req.rd_addr   = off_reg + WIN_AW'(cnt_inc);
                    produced_next     = prod_inc;
                    cnt_next          = cnt_inc;
                    if (cnt_inc == len_reg) begin
                        flag_next  = {1'b0, flag_reg[7:1]};
                        bits_next  = bits_dec;
                        phase_next = nb_phase;
                        state_next = finish_state;
                    end
                end
            end

            ST_STATUS: begin
                if (out_free) begin
                    load_out      = 1'b1;
                    out_byte      = 8'd0;
                    out_status    = 1'b1;
                    out_last      = 1'b1;
                    out_comp      = (produced_ext == expected_ext);
                    win_req.clear = 1'b1;
                    phase_next    = PH_FLAG;
                    flag_next     = 8'd0;
                    bits_next     = 4'd0;
                    offlo_next    = 8'd0;
                    produced_next = '0;
                    limit_next    = 1'b0;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            phase_reg    <= PH_FLAG;
            flag_reg     <= 8'd0;
            bits_reg     <= 4'd0;
            offlo_reg    <= 8'd0;
            cnt_reg      <= 5'd0;
            len_reg      <= 5'd0;
            produced_reg <= '0;
            limit_reg    <= 1'b0;
            expected_reg <= '0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            flag_reg     <= flag_next;
            bits_reg     <= bits_next;
            offlo_reg    <= offlo_next;
            cnt_reg      <= cnt_next;
            len_reg      <= len_next;
            produced_reg <= produced_next;
            limit_reg    <= limit_next;
            if (cfg_wr_en) begin
                expected_reg <= cfg_wr_data;
            end
        end
    end

    // Item payload and copy source need no reset.
    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        fend_reg <= fend_next;
        off_reg  <= off_next;
    end

    // Output register between the decoder and the receiver.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg   <= out_byte;
            m_status_reg <= out_status;
            m_last_reg   <= out_last;
            m_comp_reg   <= out_comp;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_comp_reg, m_data_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    lzwd_window u_window (
        .clk     (aclk),
        .rst_n   (aresetn),
        .req     (win_req),
        .rd_data (win_data)
    );

    // A window write always goes with a result entering a free output slot.
    `LZWD_CHECK(a_push_has_slot, aclk, aresetn, win_req.push, out_free && load_out, "window write without output slot")

    // The copy index stays below the match length while copying.
    `LZWD_CHECK(a_copy_in_range, aclk, aresetn, state_reg == ST_COPY, cnt_reg < len_reg, "copy index beyond match length")

    // A status item always closes its run.
    `LZWD_CHECK(a_status_last, aclk, aresetn, m_tvalid && m_tuser, m_tlast, "status item without last flag")

    // Sending the status clears the frame counters before the next item.
    `LZWD_CHECK_NEXT(a_frame_cleared, aclk, aresetn, (state_reg == ST_STATUS) && out_free, (state_reg == ST_IDLE) && (produced_reg == '0) && !limit_reg, "frame state not cleared after status")

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the LZSS window decoder: directed table, then random frames.
module tb_top;
    import lzwd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles allowed for an item that produces nothing to drain from the block:
    // a long match pair plus the status item, with margin.
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_ITEMS  = 96;
    localparam int PLAN_ROWS     = 24;

    // One decompressed result as it appears on the master channel.
    typedef struct packed {
        logic [7:0] byte_val;
        logic       status;
        logic       last;
        logic       complete;
    } dec_result_t;

    // One row of the directed table. Rows with typed set carry their single
    // expected result; the others are predicted.
    typedef struct packed {
        logic [7:0]  code;
        logic        fend;
        logic        set_len;
        logic [23:0] len_val;
        logic        typed;
        dec_result_t want;
    } plan_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;       // in_byte [7:0]
    logic        s_tlast = 1'b0;        // frame_end
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;               // out_byte [7:0], complete [8], zero [15:9]
    logic        m_tuser;               // is_status
    logic        m_tlast;               // last_of_run
    logic        cfg_wr_en = 1'b0;
    logic [23:0] cfg_wr_data = 24'h000000;

    lzss_window_decoder_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // 4 ns clock period.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Decoder state as predicted by the testbench. It mirrors the frame state
    // of the block: history window, write pointer, flag byte being consumed,
    // parser phase, pending low offset byte, output count and the stop flag.
    logic [7:0]  hist [WINDOW_DEPTH];
    logic [11:0] hist_wpos;
    logic [7:0]  ctl_flags;
    logic [3:0]  ctl_bits_left;
    phase_t      parse_ph;
    logic [7:0]  pair_lo;
    logic [23:0] out_count;
    logic        stopped;
    logic [23:0] len_goal;

    // Decompressed results that the block still owes, oldest first.
    dec_result_t due_results[$];

    bit failed;
    int tx_idle_pct;
    int rx_idle_pct;
    int live_items;
    int sent_items;
    int frames_sent;
    int len_writes;
    int results_checked;
    int status_seen;
    int cycles;

    plan_row_t plan [PLAN_ROWS];

    // Back to the start-of-frame state: window full of spaces, pointer at its
    // usual starting slot, parser waiting for a flag byte. The length goal stays.
    function automatic void restart_frame();
        foreach (hist[i]) hist[i] = BYTE_SPACE;
        hist_wpos     = WIN_START;
        ctl_flags     = 8'h00;
        ctl_bits_left = 4'd0;
        parse_ph      = PH_FLAG;
        pair_lo       = 8'h00;
        out_count     = 24'd0;
        stopped       = 1'b0;
    endfunction

    // Emits one byte unless the length goal has been reached, in which case the
    // frame stops producing and the rest of it is ignored.
    function automatic bit put_byte(input logic [7:0] v);
        if (stopped || out_count >= len_goal) begin
            stopped = 1'b1;
            return 1'b0;
        end
        due_results.push_back('{byte_val: v, status: 1'b0, last: 1'b0, complete: 1'b0});
        hist[hist_wpos] = v;
        hist_wpos = hist_wpos + 12'd1;
        if (out_count != '1) out_count = out_count + 24'd1;
        return 1'b1;
    endfunction

    function automatic void next_flag_bit();
        ctl_flags = ctl_flags >> 1;
        if (ctl_bits_left != 4'd0) ctl_bits_left = ctl_bits_left - 4'd1;
        parse_ph = (ctl_bits_left == 4'd0) ? PH_FLAG : PH_ITEM;
    endfunction

    // Works out every result that one compressed byte causes and queues them.
    function automatic void decode_step(input logic [7:0] b, input logic fend);
        int          mark;
        int          i;
        logic [11:0] src;
        logic [11:0] addr;
        logic [4:0]  run_len;
        mark = due_results.size();
        if (!stopped) begin
            live_items++;
            case (parse_ph)
                PH_ITEM: begin
                    if (ctl_flags[0]) begin
                        if (put_byte(b)) next_flag_bit();
                    end else begin
                        pair_lo  = b;
                        parse_ph = PH_PAIR2;
                    end
                end
                PH_PAIR2: begin
                    // Upper nibble extends the offset, lower nibble is the length less three.
                    src     = {b[7:4], pair_lo};
                    run_len = {1'b0, b[3:0]} + LEN_BIAS;
                    for (i = 0; i < int'(run_len); i++) begin
                        addr = src + 12'(i);
                        if (!put_byte(hist[addr])) break;
                    end
                    if (!stopped) next_flag_bit();
                end
                default: begin
                    ctl_flags     = b;
                    ctl_bits_left = FLAG_BITS;
                    parse_ph      = PH_ITEM;
                end
            endcase
        end
        if (fend) begin
            due_results.push_back('{byte_val: 8'h00, status: 1'b1, last: 1'b0,
                                    complete: (out_count == len_goal)});
            restart_frame();
        end
        if (due_results.size() > mark) due_results[due_results.size() - 1].last = 1'b1;
    endfunction

    // Length goals for the random part, the extremes among them.
    function automatic logic [23:0] pick_len();
        case ($urandom_range(0, 9))
            0: return 24'd0;
            1: return 24'hFFFFFF;
            2: return 24'($urandom);
            default: return 24'($urandom_range(1, 60));
        endcase
    endfunction

    // Writes the length register once the block has drained. This is also the
    // point where the sender holds off until every owed result has come back.
    task automatic write_len(input logic [23:0] v);
        s_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        len_goal = v;
        len_writes++;
    endtask

    // Offers one compressed byte, waits for the handshake, then predicts what
    // it causes. A typed row replaces the prediction with its own expectation
    // and must agree with it. After acceptance the sender idles cycle by cycle
    // with the current idle odds; otherwise tvalid stays high into the next item.
    task automatic feed(input logic [7:0] b, input logic fend, input logic typed,
                        input dec_result_t want);
        int mark;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fend;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_items++;
        mark = due_results.size();
        decode_step(b, fend);
        if (typed) begin
            if (due_results.size() != mark + 1 || due_results[mark] != want) begin
                $error("directed row %02h disagrees with prediction", b);
                failed = 1'b1;
            end
            while (due_results.size() > mark) void'(due_results.pop_back());
            due_results.push_back(want);
        end
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // Result checker and receiver. Outputs are sampled at the edge, before the
    // block's own updates land, and tready is redrawn for the next cycle.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (due_results.size() == 0) begin
                $error("result item with nothing expected: out_byte %02h, tuser %0b",
                       m_tdata[7:0], m_tuser);
                failed = 1'b1;
            end else begin
                if (m_tdata[7:0] != due_results[0].byte_val) begin
                    $error("out_byte: expected %02h, actual %02h",
                           due_results[0].byte_val, m_tdata[7:0]);
                    failed = 1'b1;
                end
                if (m_tuser != due_results[0].status) begin
                    $error("is_status: expected %0b, actual %0b",
                           due_results[0].status, m_tuser);
                    failed = 1'b1;
                end
                if (m_tdata[8] != due_results[0].complete) begin
                    $error("complete: expected %0b, actual %0b",
                           due_results[0].complete, m_tdata[8]);
                    failed = 1'b1;
                end
                if (m_tlast != due_results[0].last) begin
                    $error("last_of_run: expected %0b, actual %0b",
                           due_results[0].last, m_tlast);
                    failed = 1'b1;
                end
                void'(due_results.pop_front());
                results_checked++;
                if (m_tuser) status_seen++;
            end
        end
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int          k;
        int          frame_len;
        int          rand_start;
        int          progress;
        bit          noise;
        logic [7:0]  code;
        logic [7:0]  gflags;
        int          gbits;
        bit          in_pair;
        logic [11:0] goff;

        // Directed table. Columns: byte, frame end, write length first, length,
        // typed, expected {out_byte, is_status, last_of_run, complete}.
        // Right after reset the length goal is zero, so the first literal is
        // refused and the frame still ends complete.
        plan[0]  = '{8'hFF, 1'b0, 1'b0, 24'd0, 1'b0, '0};
        plan[1]  = '{8'h00, 1'b0, 1'b0, 24'd0, 1'b0, '0};
        plan[2]  = '{8'h34, 1'b1, 1'b0, 24'd0, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b1}};
        // Four literals at the byte extremes, then three match pairs: one that
        // copies its own freshly written bytes and wraps its writes past the
        // window end, one at offset zero that reads back those wrapped bytes,
        // and one near the window end that runs into the length goal partway.
        plan[3]  = '{8'h0F, 1'b0, 1'b1, 24'd40, 1'b0, '0};
        plan[4]  = '{8'h00, 1'b0, 1'b0, 24'd0, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}};
        plan[5]  = '{8'hFF, 1'b0, 1'b0, 24'd0, 1'b1, '{8'hFF, 1'b0, 1'b1, 1'b0}};
        plan[6]  = '{8'hA5, 1'b0, 1'b0, 24'd0, 1'b1, '{8'hA5, 1'b0, 1'b1, 1'b0}};
        plan[7]  = '{8'h5A, 1'b0, 1'b0, 24'd0, 1'b1, '{8'h5A, 1'b0, 1'b1, 1'b0}};
        plan[8]  = '{8'hEE, 1'b0, 1'b0, 24'd0, 1'b0, '0};
        plan[9]  = '{8'hFF, 1'b0, 1'b0, 24'd0, 1'b0, '0};
        plan[10] = '{8'h00, 1'b0, 1'b0, 24'd0, 1'b0, '0};
        plan[11] = '{8'h00, 1'b0, 1'b0, 24'd0, 1'b0, '0};
        plan[12] = '{8'hF0, 1'b0, 1'b0, 24'd0, 1'b0, '0};
        plan[13] = '{8'hFF, 1'b0, 1'b0, 24'd0, 1'b0, '0};
        // Past the goal everything is ignored; the frame ends complete.
        plan[14] = '{8'h12, 1'b0, 1'b0, 24'd0, 1'b0, '0};
        plan[15] = '{8'h34, 1'b1, 1'b0, 24'd0, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b1}};
        // Largest goal: a literal and the status come from the same item.
        plan[16] = '{8'h01, 1'b0, 1'b1, 24'hFFFFFF, 1'b0, '0};
        plan[17] = '{8'h7E, 1'b1, 1'b0, 24'd0, 1'b0, '0};
        // A pair cut off by the frame end is dropped.
        plan[18] = '{8'h00, 1'b0, 1'b0, 24'd0, 1'b0, '0};
        plan[19] = '{8'h10, 1'b1, 1'b0, 24'd0, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}};
        // Goal lowered in the middle of a frame takes effect at once.
        plan[20] = '{8'hFF, 1'b0, 1'b0, 24'd0, 1'b0, '0};
        plan[21] = '{8'h41, 1'b0, 1'b0, 24'd0, 1'b1, '{8'h41, 1'b0, 1'b1, 1'b0}};
        plan[22] = '{8'h42, 1'b0, 1'b1, 24'd1, 1'b0, '0};
        plan[23] = '{8'h43, 1'b1, 1'b0, 24'd0, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b1}};

        len_goal = 24'd0;
        restart_frame();
        tx_idle_pct = 21;
        rx_idle_pct = 49;

        // Reset held from time zero, then released on a rising edge.
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (k = 0; k < PLAN_ROWS; k++) begin
            if (plan[k].set_len) write_len(plan[k].len_val);
            feed(plan[k].code, plan[k].fend, plan[k].typed, plan[k].want);
        end
        frames_sent = 5;

        // Random frames. Most follow the format so the parser reaches literals
        // and pairs; offsets mostly point a short way back from the write
        // pointer so that copies pick up real data. About one frame in ten is
        // pure noise.
        rand_start = sent_items;
        while (sent_items - rand_start < RANDOM_ITEMS) begin
            if (frames_sent == 5 || $urandom_range(0, 2) != 0) write_len(pick_len());
            noise     = ($urandom_range(0, 9) == 0);
            frame_len = $urandom_range(2, 30);
            gbits     = 0;
            in_pair   = 1'b0;
            for (k = 0; k < frame_len; k++) begin
                progress = sent_items - rand_start;
                if (progress < RANDOM_ITEMS / 3) begin
                    tx_idle_pct = 21;
                    rx_idle_pct = 49;
                end else if (progress < 2 * RANDOM_ITEMS / 3) begin
                    tx_idle_pct = 49;
                    rx_idle_pct = 21;
                end else begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
                // Occasionally move the goal in the middle of a frame.
                if (k > 0 && $urandom_range(0, 15) == 0) write_len(pick_len());
                if (noise) begin
                    code = 8'($urandom);
                end else if (gbits == 0) begin
                    code   = 8'($urandom);
                    gflags = code;
                    gbits  = 8;
                end else if (in_pair) begin
                    code    = {goff[11:8], 4'($urandom)};
                    in_pair = 1'b0;
                    gflags  = gflags >> 1;
                    gbits--;
                end else if (gflags[0]) begin
                    code   = 8'($urandom);
                    gflags = gflags >> 1;
                    gbits--;
                end else begin
                    if ($urandom_range(0, 3) == 0) goff = 12'($urandom);
                    else goff = hist_wpos - 12'($urandom_range(1, 64));
                    code    = goff[7:0];
                    in_pair = 1'b1;
                end
                feed(code, (k == frame_len - 1), 1'b0, '0);
            end
            frames_sent++;
        end

        // Drain: everything owed must arrive, then nothing more may follow.
        s_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("summary: %0d compressed items sent, %0d decoded before a goal, %0d frames",
                 sent_items, live_items, frames_sent);
        $display("summary: %0d length writes, %0d result items checked, %0d frame status",
                 len_writes, results_checked, status_seen);
        if (!failed) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/lzwd_pkg.sv
rtl/lzwd_ram.sv
rtl/lzwd_window.sv
rtl/lzss_window_decoder_unit.sv
tb/tb_top.sv
